// ===== sv/rhsv_pkg.sv =====
// rhsv_pkg: shared types and constants for the RGB to HSV converter.
// Depends on nothing; used by every other file of the block.
package rhsv_pkg;

    localparam int PIX_W              = 8;
    localparam int HUE_W              = 15;
    localparam int SAT_W              = 16;
    localparam int HUE_FRAC_BITS_DEF  = 6;
    localparam int SAT_BITS_DEF       = 16;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        t_sector            sector;
        logic               neg;
        logic               grey;
        logic               black;
        logic [PIX_W-1:0]   value;
        logic [PIX_W-1:0]   alpha;
    } t_side;

endpackage

// ===== sv/rhsv_if.sv =====
// rhsv_if: valid/ready channel interfaces for pixel words in and HSV words out.
// Depends on rhsv_pkg for field widths.
interface rhsv_in_if;
    logic                       valid;
    logic                       ready;
    logic [rhsv_pkg::PIX_W-1:0] red;
    logic [rhsv_pkg::PIX_W-1:0] green;
    logic [rhsv_pkg::PIX_W-1:0] blue;
    logic [rhsv_pkg::PIX_W-1:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface rhsv_out_if;
    logic                       valid;
    logic                       ready;
    logic [rhsv_pkg::HUE_W-1:0] hue;
    logic [rhsv_pkg::SAT_W-1:0] saturation;
    logic [rhsv_pkg::PIX_W-1:0] value;
    logic [rhsv_pkg::PIX_W-1:0] alpha_out;

    modport source (output valid, hue, saturation, value, alpha_out, input ready);
    modport sink   (input valid, hue, saturation, value, alpha_out, output ready);
endinterface

// ===== sv/rgb_to_hsv_converter.sv =====
// rgb_to_hsv_converter: RGBA to HSVA pixel converter, fully pipelined.
// The bit-per-stage dividers set the pipeline depth. Throughput: one word per cycle
// while the output register is empty or o_hsv.ready is high.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
// Depends on rhsv_pkg, rhsv_if, rhsv_front, rhsv_div, rhsv_post.
module rgb_to_hsv_converter #(
    parameter int HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int SAT_BITS      = rhsv_pkg::SAT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rhsv_in_if.sink     i_pix,
    rhsv_out_if.source  o_hsv
);
    localparam int PW      = rhsv_pkg::PIX_W;
    localparam int QH      = HUE_FRAC_BITS + 6;
    localparam int DIV_LAT = (QH > SAT_BITS) ? QH : SAT_BITS;

    logic                  en;
    logic                  f_valid;
    rhsv_pkg::t_side       f_side;
    logic [QH+PW-1:0]      f_hue_num;
    logic [SAT_BITS+PW-1:0] f_sat_num;
    logic [PW-1:0]         f_delta;
    logic [PW-1:0]         f_max;
    logic [QH-1:0]         hue_quo;
    logic [SAT_BITS-1:0]   sat_quo;
    logic                  out_valid;

    logic                  r_dvalid [DIV_LAT];
    rhsv_pkg::t_side       r_dside  [DIV_LAT];

    assign en          = !out_valid || o_hsv.ready;
    assign i_pix.ready = en;
    assign o_hsv.valid = out_valid;

    rhsv_front #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS),
        .SAT_BITS     (SAT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_pix.valid),
        .i_red    (i_pix.red),
        .i_green  (i_pix.green),
        .i_blue   (i_pix.blue),
        .i_alpha  (i_pix.alpha),
        .o_valid  (f_valid),
        .o_side   (f_side),
        .o_hue_num(f_hue_num),
        .o_sat_num(f_sat_num),
        .o_delta  (f_delta),
        .o_max    (f_max)
    );

    rhsv_div #(.QW(QH), .LAT(DIV_LAT)) u_hue_div (
        .i_clk(i_clk),
        .i_en (en),
        .i_num(f_hue_num),
        .i_den(f_delta),
        .o_quo(hue_quo)
    );

    rhsv_div #(.QW(SAT_BITS), .LAT(DIV_LAT)) u_sat_div (
        .i_clk(i_clk),
        .i_en (en),
        .i_num(f_sat_num),
        .i_den(f_max),
        .o_quo(sat_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_dvalid[i] <= 1'b0;
        end else if (en) begin
            r_dvalid[0] <= f_valid;
            for (int i = 1; i < DIV_LAT; i++) r_dvalid[i] <= r_dvalid[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dside[0] <= f_side;
            for (int i = 1; i < DIV_LAT; i++) r_dside[i] <= r_dside[i-1];
        end
    end

    rhsv_post #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS),
        .SAT_BITS     (SAT_BITS)
    ) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_dvalid[DIV_LAT-1]),
        .i_side      (r_dside[DIV_LAT-1]),
        .i_hue_quo   (hue_quo),
        .i_sat_quo   (sat_quo),
        .o_valid     (out_valid),
        .o_hue       (o_hsv.hue),
        .o_saturation(o_hsv.saturation),
        .o_value     (o_hsv.value),
        .o_alpha_out (o_hsv.alpha_out)
    );
endmodule

// ===== sv/rhsv_front.sv =====
// rhsv_front: two pipeline stages; max/min/sector, then scaled dividends.
// Depends on rhsv_pkg.
module rhsv_front #(
    parameter int HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int SAT_BITS      = rhsv_pkg::SAT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [rhsv_pkg::PIX_W-1:0]            i_red,
    input  logic [rhsv_pkg::PIX_W-1:0]            i_green,
    input  logic [rhsv_pkg::PIX_W-1:0]            i_blue,
    input  logic [rhsv_pkg::PIX_W-1:0]            i_alpha,
    output logic                                  o_valid,
    output rhsv_pkg::t_side                       o_side,
    output logic [HUE_FRAC_BITS+6+rhsv_pkg::PIX_W-1:0] o_hue_num,
    output logic [SAT_BITS+rhsv_pkg::PIX_W-1:0]   o_sat_num,
    output logic [rhsv_pkg::PIX_W-1:0]            o_delta,
    output logic [rhsv_pkg::PIX_W-1:0]            o_max
);
    localparam int PW   = rhsv_pkg::PIX_W;
    localparam int HN_W = HUE_FRAC_BITS + 6 + PW;
    localparam int SN_W = SAT_BITS + PW;
    localparam logic [HN_W-1:0] HUE_SCALE = HN_W'(60 << HUE_FRAC_BITS);

    logic            r_a_valid;
    rhsv_pkg::t_side r_a_side;
    logic [PW-1:0]   r_a_absn;
    logic [PW-1:0]   r_a_delta;
    logic [PW-1:0]   r_a_max;

    logic            r_b_valid;
    rhsv_pkg::t_side r_b_side;
    logic [HN_W-1:0] r_b_hnum;
    logic [SN_W-1:0] r_b_snum;
    logic [PW-1:0]   r_b_delta;
    logic [PW-1:0]   r_b_max;

    rhsv_pkg::t_side n_a_side;
    logic [PW-1:0]   n_a_absn;
    logic [PW-1:0]   mx;
    logic [PW-1:0]   mn;
    logic [PW:0]     diff;
    logic [PW:0]     mag;

    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;

        if (mx == i_red) begin
            n_a_side.sector = rhsv_pkg::SEC_RED;
            diff = {1'b0, i_green} - {1'b0, i_blue};
        end else if (mx == i_green) begin
            n_a_side.sector = rhsv_pkg::SEC_GREEN;
            diff = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_a_side.sector = rhsv_pkg::SEC_BLUE;
            diff = {1'b0, i_red} - {1'b0, i_green};
        end
        mag            = diff[PW] ? (~diff + 1'b1) : diff;
        n_a_absn       = mag[PW-1:0];
        n_a_side.neg   = diff[PW];
        n_a_side.grey  = (mx == mn);
        n_a_side.black = (mx == '0);
        n_a_side.value = mx;
        n_a_side.alpha = i_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side  <= n_a_side;
            r_a_absn  <= n_a_absn;
            r_a_delta <= mx - mn;
            r_a_max   <= mx;
            r_b_side  <= r_a_side;
            r_b_hnum  <= HN_W'(r_a_absn) * HUE_SCALE;
            r_b_snum  <= (SN_W'(r_a_delta) << SAT_BITS) - SN_W'(r_a_delta);
            r_b_delta <= r_a_delta;
            r_b_max   <= r_a_max;
        end
    end

    assign o_valid   = r_b_valid;
    assign o_side    = r_b_side;
    assign o_hue_num = r_b_hnum;
    assign o_sat_num = r_b_snum;
    assign o_delta   = r_b_delta;
    assign o_max     = r_b_max;
endmodule

// ===== sv/rhsv_div.sv =====
// rhsv_div: pipelined restoring divider by an 8-bit divisor, one quotient bit per stage in its
// last QW stages (earlier stages pass operands through). Dividend must satisfy num < den * 2^QW. Depends on rhsv_pkg.
module rhsv_div #(
    parameter int QW  = rhsv_pkg::SAT_BITS_DEF,
    parameter int LAT = rhsv_pkg::SAT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [QW+rhsv_pkg::PIX_W-1:0]   i_num,
    input  logic [rhsv_pkg::PIX_W-1:0]      i_den,
    output logic [QW-1:0]                   o_quo
);
    localparam int PW = rhsv_pkg::PIX_W;

    logic [PW-1:0] r_rem [LAT];
    logic [QW-1:0] r_quo [LAT];
    logic [PW-1:0] r_den [LAT];
    logic [PW-1:0] n_rem [LAT];
    logic [QW-1:0] n_quo [LAT];
    logic [PW-1:0] n_den [LAT];

    always_comb begin
        logic [PW-1:0] rin;
        logic [QW-1:0] qin;
        logic [PW-1:0] din;
        logic [PW:0]   t;
        logic          ge;
        for (int i = 0; i < LAT; i++) begin
            if (i == 0) begin
                rin = i_num[QW+PW-1:QW];
                qin = i_num[QW-1:0];
                din = i_den;
            end else begin
                rin = r_rem[i-1];
                qin = r_quo[i-1];
                din = r_den[i-1];
            end
            t  = {rin, qin[QW-1]};
            ge = (t >= {1'b0, din});
            n_den[i] = din;
            if (i >= LAT - QW) begin
                n_rem[i] = ge ? PW'(t - {1'b0, din}) : t[PW-1:0];
                n_quo[i] = {qin[QW-2:0], ge};
            end else begin
                n_rem[i] = rin;
                n_quo[i] = qin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LAT; i++) begin
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
                r_den[i] <= n_den[i];
            end
        end
    end

    assign o_quo = r_quo[LAT-1];
endmodule

// ===== sv/rhsv_post.sv =====
// rhsv_post: applies quotient sign and sector offset, output register stage.
// Zero hue if grey, zero saturation if black. Depends on rhsv_pkg.
module rhsv_post #(
    parameter int HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEF,
    parameter int SAT_BITS      = rhsv_pkg::SAT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  rhsv_pkg::t_side                 i_side,
    input  logic [HUE_FRAC_BITS+5:0]        i_hue_quo,
    input  logic [SAT_BITS-1:0]             i_sat_quo,
    output logic                            o_valid,
    output logic [rhsv_pkg::HUE_W-1:0]      o_hue,
    output logic [rhsv_pkg::SAT_W-1:0]      o_saturation,
    output logic [rhsv_pkg::PIX_W-1:0]      o_value,
    output logic [rhsv_pkg::PIX_W-1:0]      o_alpha_out
);
    localparam int HB_W = HUE_FRAC_BITS + 10;
    localparam logic [HB_W-1:0] DEG120 = HB_W'(120 << HUE_FRAC_BITS);
    localparam logic [HB_W-1:0] DEG240 = HB_W'(240 << HUE_FRAC_BITS);
    localparam logic [HB_W-1:0] DEG360 = HB_W'(360 << HUE_FRAC_BITS);

    logic                       r_valid;
    logic [rhsv_pkg::HUE_W-1:0] r_hue;
    logic [rhsv_pkg::SAT_W-1:0] r_sat;
    logic [rhsv_pkg::PIX_W-1:0] r_value;
    logic [rhsv_pkg::PIX_W-1:0] r_alpha;

    logic [HB_W-1:0] q;
    logic [HB_W-1:0] h;

    always_comb begin
        q = HB_W'(i_hue_quo);
        case (i_side.sector)
            rhsv_pkg::SEC_RED:   h = (i_side.neg && q != '0) ? DEG360 - q : q;
            rhsv_pkg::SEC_GREEN: h = i_side.neg ? DEG120 - q : DEG120 + q;
            rhsv_pkg::SEC_BLUE:  h = i_side.neg ? DEG240 - q : DEG240 + q;
            default:             h = '0;
        endcase
        if (i_side.grey) h = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue   <= rhsv_pkg::HUE_W'(h);
            r_sat   <= i_side.black ? '0 : rhsv_pkg::SAT_W'(i_sat_quo);
            r_value <= i_side.value;
            r_alpha <= i_side.alpha;
        end
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_value      = r_value;
    assign o_alpha_out  = r_alpha;
endmodule

// ===== dv/rgb_to_hsv_converter_tb.sv =====
// rgb_to_hsv_converter_tb: self-checking bench for the RGBA to HSVA converter.
// Directed and random pixels with random gaps and backpressure; a built-in HSV predictor.
// Depends on rhsv_pkg, rhsv_if and the converter RTL.
module rgb_to_hsv_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W         = rhsv_pkg::PIX_W;
    localparam int HUE_W         = rhsv_pkg::HUE_W;
    localparam int SAT_W         = rhsv_pkg::SAT_W;
    localparam int HUE_UNIT      = 1 << rhsv_pkg::HUE_FRAC_BITS_DEF;
    localparam int SAT_SCALE     = (1 << rhsv_pkg::SAT_BITS_DEF) - 1;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 40;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [PIX_W-1:0] value;
        logic [PIX_W-1:0] alpha;
    } t_hsv_word;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rhsv_in_if  pix_if ();
    rhsv_out_if hsv_if ();

    rgb_to_hsv_converter uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_if.sink),
        .o_hsv   (hsv_if.source)
    );

    always #4 clk = ~clk;

    t_hsv_word pending_hsv[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        gaps_on        = 1'b1;
    bit        sink_stalls    = 1'b1;
    bit        hold_req       = 1'b0;

    function automatic t_hsv_word rgb_to_hsv_predict(input logic [PIX_W-1:0] r,
                                                     input logic [PIX_W-1:0] g,
                                                     input logic [PIX_W-1:0] b,
                                                     input logic [PIX_W-1:0] a);
        int        rr, gg, bb, mx, mn, delta, hue;
        longint    sat;
        t_hsv_word w;
        rr = int'(r);
        gg = int'(g);
        bb = int'(b);
        mx = rr;
        mn = rr;
        if (gg > mx) mx = gg;
        if (bb > mx) mx = bb;
        if (gg < mn) mn = gg;
        if (bb < mn) mn = bb;
        delta = mx - mn;
        hue = 0;
        if (delta != 0) begin
            if (mx == rr) begin
                hue = (60 * HUE_UNIT * (gg - bb)) / delta;
                if (hue < 0) hue += 360 * HUE_UNIT;
            end else if (mx == gg) begin
                hue = (60 * HUE_UNIT * (bb - rr)) / delta + 120 * HUE_UNIT;
            end else begin
                hue = (60 * HUE_UNIT * (rr - gg)) / delta + 240 * HUE_UNIT;
            end
        end
        sat = 0;
        if (mx != 0) sat = (longint'(delta) * SAT_SCALE) / mx;
        w.hue        = hue[HUE_W-1:0];
        w.saturation = sat[SAT_W-1:0];
        w.value      = mx[PIX_W-1:0];
        w.alpha      = a;
        return w;
    endfunction

    // mostly short, a few long
    function automatic int pick_gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75) return $urandom_range(1, 3);
        if (p < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] a);
        @(negedge clk);
        pix_if.valid <= 1'b1;
        pix_if.red   <= r;
        pix_if.green <= g;
        pix_if.blue  <= b;
        pix_if.alpha <= a;
        do @(posedge clk); while (!pix_if.ready);
        pending_hsv.push_back(rgb_to_hsv_predict(r, g, b, a));
    endtask

    task automatic pixel_gap(input int n);
        if (n > 0) begin
            @(negedge clk);
            pix_if.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 2) == 0) pixel_gap(pick_gap_len());
    endtask

    task automatic wait_drained();
        while (pending_hsv.size() != 0) @(posedge clk);
    endtask

    task automatic send_random_pixel();
        send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
    endtask

    // pixels shaped toward ties, grey, small deltas and dark values
    task automatic send_shaped_pixel();
        logic [PIX_W-1:0] c[3];
        int               hi, lo, k, j;
        hi = $urandom_range(0, 255);
        lo = $urandom_range(0, hi);
        k  = $urandom_range(0, 2);
        j  = (k + $urandom_range(1, 2)) % 3;
        for (int i = 0; i < 3; i++) c[i] = PIX_W'($urandom_range(lo, hi));
        case ($urandom_range(0, 5))
            0: for (int i = 0; i < 3; i++) c[i] = PIX_W'(hi);
            1: begin
                c[k] = PIX_W'(hi);
                c[j] = PIX_W'(hi);
            end
            2: begin
                for (int i = 0; i < 3; i++) c[i] = PIX_W'(hi);
                c[j] = PIX_W'((hi > 3) ? hi - $urandom_range(1, 3) : 0);
            end
            3: begin
                for (int i = 0; i < 3; i++) c[i] = PIX_W'($urandom_range(0, 3));
            end
            4: begin
                c[k] = PIX_W'(hi);
                c[j] = PIX_W'(lo);
            end
            default: ;
        endcase
        send_pixel(c[0], c[1], c[2], PIX_W'($urandom));
    endtask

    task automatic test_directed();
        send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd170);
        send_pixel(8'd128, 8'd128, 8'd128, 8'd85);
        send_pixel(8'd255, 8'd0,   8'd0,   8'd1);
        send_pixel(8'd0,   8'd255, 8'd0,   8'd2);
        send_pixel(8'd0,   8'd0,   8'd255, 8'd4);
        send_pixel(8'd255, 8'd255, 8'd0,   8'd8);
        send_pixel(8'd0,   8'd255, 8'd255, 8'd16);
        send_pixel(8'd255, 8'd0,   8'd255, 8'd32);
        send_pixel(8'd200, 8'd200, 8'd200, 8'd64);
        send_pixel(8'd255, 8'd0,   8'd10,  8'd128);
        send_pixel(8'd255, 8'd254, 8'd255, 8'd127);
        send_pixel(8'd1,   8'd0,   8'd0,   8'd254);
        send_pixel(8'd0,   8'd1,   8'd0,   8'd253);
        send_pixel(8'd0,   8'd0,   8'd1,   8'd251);
        send_pixel(8'd255, 8'd254, 8'd254, 8'd247);
        send_pixel(8'd254, 8'd255, 8'd0,   8'd239);
        send_pixel(8'd1,   8'd0,   8'd255, 8'd223);
        send_pixel(8'd100, 8'd50,  8'd255, 8'd191);
        send_pixel(8'd1,   8'd1,   8'd0,   8'd255);
        pixel_gap(1);
        wait_drained();
    endtask

    task automatic test_random_pixels();
        for (int i = 0; i < 500; i++) begin
            if (i % 100 == 0) begin
                gaps_on     = (i % 200 == 0);
                sink_stalls = (i % 300 != 0);
            end
            send_random_pixel();
            maybe_gap();
        end
        gaps_on     = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++) send_random_pixel();
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 40; i++) begin
            send_shaped_pixel();
            maybe_gap();
        end
        pixel_gap(1);
        wait_drained();
        for (int i = 0; i < 40; i++) begin
            send_shaped_pixel();
            maybe_gap();
        end
    endtask

    task automatic test_shaped_pixels();
        for (int i = 0; i < 500; i++) begin
            if (i % 125 == 0) gaps_on = (i % 250 == 0);
            send_shaped_pixel();
            maybe_gap();
        end
        gaps_on = 1'b1;
    endtask

    // output side: random stalls and the long hold
    initial begin
        int stall_left;
        stall_left = 0;
        hsv_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hsv_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (!sink_stalls) begin
                hsv_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                hsv_if.ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap_len() - 1;
                hsv_if.ready <= 1'b0;
            end else begin
                hsv_if.ready <= 1'b1;
            end
        end
    end

    // result checker and watchdog
    always @(posedge clk) begin
        t_hsv_word want;
        if (rst_n) begin
            if ((hsv_if.valid && hsv_if.ready) || (pix_if.valid && pix_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (hsv_if.valid && hsv_if.ready) begin
                if (pending_hsv.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected word: hue=%0d sat=%0d val=%0d a=%0d",
                                 hsv_if.hue, hsv_if.saturation, hsv_if.value,
                                 hsv_if.alpha_out);
                end else begin
                    want = pending_hsv.pop_front();
                    if (hsv_if.hue !== want.hue || hsv_if.saturation !== want.saturation ||
                        hsv_if.value !== want.value || hsv_if.alpha_out !== want.alpha) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"mismatch: exp hue=%0d sat=%0d val=%0d a=%0d,",
                                      " got hue=%0d sat=%0d val=%0d a=%0d"},
                                     want.hue, want.saturation, want.value, want.alpha,
                                     hsv_if.hue, hsv_if.saturation, hsv_if.value,
                                     hsv_if.alpha_out);
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("timeout: %0d words still expected", pending_hsv.size());
                $display("[rgb_to_hsv_converter] ERROR");
                $finish;
            end
        end
    end

    initial begin
        pix_if.valid = 1'b0;
        pix_if.red   = '0;
        pix_if.green = '0;
        pix_if.blue  = '0;
        pix_if.alpha = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_pixels();
        test_output_hold();
        test_sender_pause();
        test_shaped_pixels();

        pixel_gap(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[rgb_to_hsv_converter] OK");
        else
            $display("[rgb_to_hsv_converter] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rhsv_pkg.sv
sv/rhsv_if.sv
sv/rhsv_front.sv
sv/rhsv_div.sv
sv/rhsv_post.sv
sv/rgb_to_hsv_converter.sv
dv/rgb_to_hsv_converter_tb.sv
